// ----- design/tsp_pkg.sv -----
`default_nettype none

package tsp_pkg;

   // Request kinds
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_PIXEL   = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   // Register indexes
   localparam int unsigned CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] REG_ENABLED      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_FAST = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FAST_PERIOD  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOW_PERIOD  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FLASHES      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LED_COUNT    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LEFT_COLOR   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RIGHT_COLOR  = 4'd7;
   localparam int unsigned CSR_DATA_W = 24;

   // Strip length cap
   localparam logic [10:0] MAX_LEDS = 11'd1024;

   typedef struct packed {
      logic        enabled;
      logic        pattern_fast;
      logic [15:0] fast_period_ms;
      logic [15:0] slow_period_ms;
      logic [3:0]  flashes_per_side;
      logic [10:0] led_count;
      logic [23:0] left_color;
      logic [23:0] right_color;
   } cfg_type;

   typedef struct packed {
      logic [15:0] cycle_position;
      logic [15:0] flash_accumulator;
      logic [3:0]  flash_counter;
   } anim_type;

endpackage

`default_nettype wire

// ----- design/tsp_if.sv -----
`default_nettype none

interface tsp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [15:0] delta_ms;
   logic [9:0]  pixel_index;

   modport source (output valid, output mode, output delta_ms, output pixel_index,
                   input ready);
   modport sink   (input valid, input mode, input delta_ms, input pixel_index,
                   output ready);
endinterface

interface tsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] pixel_color;
   logic        pixel_drawn;
   logic        left_side_lit;
   logic        flash_on;

   modport source (output valid, output pixel_color, output pixel_drawn,
                   output left_side_lit, output flash_on, input ready);
   modport sink   (input valid, input pixel_color, input pixel_drawn,
                   input left_side_lit, input flash_on, output ready);
endinterface

interface tsp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tsp_pkg::CSR_IDX_W-1:0]    index;
   logic [tsp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/tsp_regs.sv -----
`default_nettype none

module tsp_regs (
   input  wire logic         clock,
   input  wire logic         reset,
   tsp_csr_if.sink           csr,
   output tsp_pkg::cfg_type  cfg,
   output logic              enable_rise
);

   tsp_pkg::cfg_type cfg_ff;
   logic             wr;

   assign csr.ready   = 1'b1;
   assign wr          = csr.valid;
   assign cfg         = cfg_ff;
   // off-to-on write restarts the animation
   assign enable_rise = wr && (csr.index == tsp_pkg::REG_ENABLED) && csr.data[0]
                        && !cfg_ff.enabled;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enabled          <= 1'b0;
         cfg_ff.pattern_fast     <= 1'b1;
         cfg_ff.fast_period_ms   <= 16'd500;
         cfg_ff.slow_period_ms   <= 16'd1000;
         cfg_ff.flashes_per_side <= 4'd3;
         cfg_ff.led_count        <= 11'd0;
         cfg_ff.left_color       <= 24'hFF0000;
         cfg_ff.right_color      <= 24'h0000FF;
      end else if (wr) begin
         case (csr.index)
            tsp_pkg::REG_ENABLED:      cfg_ff.enabled          <= csr.data[0];
            tsp_pkg::REG_PATTERN_FAST: cfg_ff.pattern_fast     <= csr.data[0];
            tsp_pkg::REG_FAST_PERIOD:  cfg_ff.fast_period_ms   <= csr.data[15:0];
            tsp_pkg::REG_SLOW_PERIOD:  cfg_ff.slow_period_ms   <= csr.data[15:0];
            tsp_pkg::REG_FLASHES:      cfg_ff.flashes_per_side <= csr.data[3:0];
            tsp_pkg::REG_LED_COUNT:    cfg_ff.led_count        <= csr.data[10:0];
            tsp_pkg::REG_LEFT_COLOR:   cfg_ff.left_color       <= csr.data[23:0];
            tsp_pkg::REG_RIGHT_COLOR:  cfg_ff.right_color      <= csr.data[23:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- design/tsp_anim.sv -----
`default_nettype none

module tsp_anim (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tsp_pkg::cfg_type  cfg,
   input  wire logic              enable_rise,
   input  wire logic              step,
   input  wire logic [1:0]        mode,
   input  wire logic [15:0]       delta_ms,
   output tsp_pkg::anim_type      anim
);

   tsp_pkg::anim_type anim_ff;
   tsp_pkg::anim_type anim_in;

   logic        clear;
   logic        tick;
   logic [16:0] pos_sum;
   logic [19:0] gain;
   logic [20:0] acc_sum;
   logic [3:0]  cnt_inc;
   logic        left_lit;
   logic [15:0] half_up;

   assign anim     = anim_ff;
   assign clear    = enable_rise || (step && mode == tsp_pkg::MODE_RESTART);
   assign tick     = step && mode == tsp_pkg::MODE_TICK && cfg.enabled;

   assign pos_sum  = {1'b0, anim_ff.cycle_position} + {1'b0, delta_ms};
   assign gain     = {4'b0, delta_ms} * {16'b0, cfg.flashes_per_side};
   assign acc_sum  = {5'b0, anim_ff.flash_accumulator} + {1'b0, gain};
   assign cnt_inc  = anim_ff.flash_counter + 4'd1;
   assign left_lit = {anim_ff.cycle_position, 1'b0} < {1'b0, cfg.slow_period_ms};
   // ceil(slow/2): phase where the right side starts
   assign half_up  = {1'b0, cfg.slow_period_ms[15:1]} + {15'b0, cfg.slow_period_ms[0]};

   always_comb begin
      anim_in = anim_ff;
      if (clear) begin
         anim_in = '0;
      end else if (tick) begin
         if (!cfg.pattern_fast) begin
            anim_in.cycle_position = (pos_sum >= {1'b0, cfg.slow_period_ms}) ? 16'd0
                                                                             : pos_sum[15:0];
         end else if (acc_sum >= {5'b0, cfg.fast_period_ms}) begin
            anim_in.flash_accumulator = 16'd0;
            if (cnt_inc >= cfg.flashes_per_side) begin
               anim_in.flash_counter  = 4'd0;
               anim_in.cycle_position = left_lit ? half_up : 16'd0;
            end else begin
               anim_in.flash_counter  = cnt_inc;
            end
         end else begin
            anim_in.flash_accumulator = acc_sum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anim_ff <= '0;
      end else begin
         anim_ff <= anim_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      clear |=> anim_ff == '0)
      else $error("animation state not cleared");
   a_disabled_holds: assert property (@(posedge clock) disable iff (reset)
      (step && mode == tsp_pkg::MODE_TICK && !cfg.enabled && !enable_rise)
      |=> $stable(anim_ff))
      else $error("disabled tick changed state");
`endif

endmodule

`default_nettype wire

// ----- design/tsp_pixel.sv -----
`default_nettype none

module tsp_pixel (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tsp_pkg::cfg_type   cfg,
   input  wire tsp_pkg::anim_type  anim,
   input  wire logic               load,
   input  wire logic [9:0]         pixel_index,
   tsp_rsp_if.source               rsp
);

   logic        valid_ff;
   logic [23:0] color_ff, color_in;
   logic        drawn_ff, drawn_in;
   logic        left_ff,  left_in;
   logic        on_ff,    on_in;

   logic [10:0] count;
   logic [10:0] half;
   logic        in_left;
   logic        left_lit;
   logic        lit;

   assign count    = (cfg.led_count > tsp_pkg::MAX_LEDS) ? tsp_pkg::MAX_LEDS : cfg.led_count;
   assign half     = {1'b0, count[10:1]};
   assign in_left  = {1'b0, pixel_index} < half;
   assign left_lit = {anim.cycle_position, 1'b0} < {1'b0, cfg.slow_period_ms};
   assign lit      = cfg.pattern_fast ?
                     ({anim.flash_accumulator, 1'b0} < {1'b0, cfg.fast_period_ms}) : 1'b1;

   always_comb begin
      drawn_in = cfg.enabled && ({1'b0, pixel_index} < count);
      left_in  = drawn_in && left_lit;
      on_in    = drawn_in && lit;
      color_in = 24'd0;
      if (on_in) begin
         if (left_in && in_left) begin
            color_in = cfg.left_color;
         end else if (!left_in && !in_left) begin
            color_in = cfg.right_color;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         color_ff <= color_in;
         drawn_ff <= drawn_in;
         left_ff  <= left_in;
         on_ff    <= on_in;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.pixel_color   = color_ff;
   assign rsp.pixel_drawn   = drawn_ff;
   assign rsp.left_side_lit = left_ff;
   assign rsp.flash_on      = on_ff;

endmodule

`default_nettype wire

// ----- design/two_side_strobe_pattern_top.sv -----
// Two-sided warning-light pattern generator for an LED strip.
// req_ch : requests of three kinds. A tick advances the animation by delta_ms
//          milliseconds, a pixel request asks for the color of one LED, a
//          restart clears the animation. Tick and restart return nothing.
// rsp_ch : one response per pixel request: color, drawn flag, lit side and
//          flash phase, in request order.
// csr_ch : register writes (index, data); always ready, one per cycle.
//          Write registers only while no request is in flight.
// Pipeline: a pixel request passes through the input register, then the
//          response register, before it shows on rsp_ch.
// Throughput: one request per cycle, any mix of kinds, while no pixel request
//          waits on a stalled rsp_ch. State update and pixel compute sit
//          between the two registers.
// Stall: with rsp_ch.ready low, the response register holds; the input
//          register keeps draining ticks and restarts, and a pixel request
//          waits in it, at which point req_ch.ready drops.
// Reset (synchronous, active high): registers go to their defaults, the
//          animation state clears, both registers empty.
`default_nettype none

module two_side_strobe_pattern_top (
   input  wire logic  clock,
   input  wire logic  reset,
   tsp_req_if.sink    req_ch,
   tsp_rsp_if.source  rsp_ch,
   tsp_csr_if.sink    csr_ch
);

   tsp_pkg::cfg_type  cfg;
   tsp_pkg::anim_type anim;
   logic              enable_rise;

   // input register
   logic        stage_valid_ff;
   logic [1:0]  stage_mode_ff;
   logic [15:0] stage_delta_ff;
   logic [9:0]  stage_index_ff;

   logic rsp_free;
   logic stage_go;
   logic stage_pixel;
   logic req_take;

   assign rsp_free    = !rsp_ch.valid || rsp_ch.ready;
   assign stage_pixel = stage_mode_ff == tsp_pkg::MODE_PIXEL;
   // only a pixel request needs room in the response register
   assign stage_go    = stage_valid_ff && (!stage_pixel || rsp_free);
   assign req_ch.ready = !stage_valid_ff || stage_go;
   assign req_take    = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         stage_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_mode_ff  <= req_ch.mode;
         stage_delta_ff <= req_ch.delta_ms;
         stage_index_ff <= req_ch.pixel_index;
      end
   end

   tsp_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ch),
      .cfg         (cfg),
      .enable_rise (enable_rise)
   );

   tsp_anim u_anim (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .enable_rise (enable_rise),
      .step        (stage_go),
      .mode        (stage_mode_ff),
      .delta_ms    (stage_delta_ff),
      .anim        (anim)
   );

   tsp_pixel u_pixel (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .anim        (anim),
      .load        (stage_go && stage_pixel),
      .pixel_index (stage_index_ff),
      .rsp         (rsp_ch)
   );

`ifndef SYNTHESIS
   a_pixel_responds: assert property (@(posedge clock) disable iff (reset)
      (stage_go && stage_pixel) |=> rsp_ch.valid)
      else $error("pixel request produced no response");
   a_no_phantom_rsp: assert property (@(posedge clock) disable iff (reset)
      (!(stage_go && stage_pixel) && rsp_ch.valid && rsp_ch.ready) |=> !rsp_ch.valid)
      else $error("response appeared without a pixel request");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(rsp_ch.pixel_color)))
      else $error("stalled response changed");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;

   // Mode 3 has no meaning in the block; it must be swallowed without a response.
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   // Generous wall: a few hundred requests at worst-case gaps and stalls fit many times over.
   localparam int unsigned RUN_LIMIT = 400000;

   typedef struct {
      logic [1:0]  mode;
      logic [15:0] delta_ms;
      logic [9:0]  pixel_index;
      int unsigned gap;          // idle cycles on req_ch before this request shows
   } strobe_req_type;

   typedef struct packed {
      logic [23:0] pixel_color;
      logic        pixel_drawn;
      logic        left_side_lit;
      logic        flash_on;
   } pixel_answer_type;

   logic clock;
   logic reset;

   tsp_req_if req_ch ();
   tsp_rsp_if rsp_ch ();
   tsp_csr_if csr_ch ();

   two_side_strobe_pattern_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow of the register file and of the animation state, kept in step with
   // the block: registers on csr acceptance, animation on request acceptance.
   tsp_pkg::cfg_type  cfg;
   tsp_pkg::anim_type anim;

   strobe_req_type   req_backlog[$];     // requests not yet presented on req_ch
   pixel_answer_type pixel_answers[$];   // predicted responses, oldest first
   strobe_req_type   req_now;            // request currently on req_ch
   int unsigned      req_wait;
   int unsigned      rsp_wait;
   logic             rsp_calm;
   int unsigned      reqs_queued;
   int unsigned      reqs_taken;
   int unsigned      mismatches;
   logic             req_calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #RUN_LIMIT;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Left half owns the phase while twice the cycle position is under the slow period.
   function automatic logic left_phase_now();
      return (32'(anim.cycle_position) << 1) < 32'(cfg.slow_period_ms);
   endfunction

   // Advance the shadow animation by one request; a pixel request queues its answer.
   function automatic void strobe_apply(input strobe_req_type r);
      int unsigned      sum;
      int unsigned      count;
      logic             in_left;
      pixel_answer_type ans;
      case (r.mode)
         tsp_pkg::MODE_TICK: begin
            if (cfg.enabled && !cfg.pattern_fast) begin
               sum = 32'(anim.cycle_position) + 32'(r.delta_ms);
               anim.cycle_position = (sum >= 32'(cfg.slow_period_ms)) ? 16'd0 : sum[15:0];
            end else if (cfg.enabled) begin
               sum = 32'(anim.flash_accumulator)
                   + 32'(r.delta_ms) * 32'(cfg.flashes_per_side);
               if (sum >= 32'(cfg.fast_period_ms)) begin
                  // flash complete; after the set number of flashes the lit side swaps
                  anim.flash_accumulator = 16'd0;
                  anim.flash_counter = anim.flash_counter + 4'd1;
                  if (anim.flash_counter >= cfg.flashes_per_side) begin
                     anim.flash_counter = 4'd0;
                     anim.cycle_position = left_phase_now()
                        ? cfg.slow_period_ms - (cfg.slow_period_ms >> 1) : 16'd0;
                  end
               end else begin
                  anim.flash_accumulator = sum[15:0];
               end
            end
         end
         tsp_pkg::MODE_RESTART: anim = '0;
         tsp_pkg::MODE_PIXEL: begin
            count = (cfg.led_count > tsp_pkg::MAX_LEDS) ? 32'(tsp_pkg::MAX_LEDS)
                                                        : 32'(cfg.led_count);
            ans = '0;
            if (cfg.enabled && 32'(r.pixel_index) < count) begin
               in_left = 32'(r.pixel_index) < count / 2;
               ans.pixel_drawn = 1'b1;
               ans.left_side_lit = left_phase_now();
               ans.flash_on = cfg.pattern_fast
                  ? ((32'(anim.flash_accumulator) << 1) < 32'(cfg.fast_period_ms)) : 1'b1;
               if (ans.flash_on && ans.left_side_lit && in_left)
                  ans.pixel_color = cfg.left_color;
               else if (ans.flash_on && !ans.left_side_lit && !in_left)
                  ans.pixel_color = cfg.right_color;
            end
            pixel_answers.push_back(ans);
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: pops the backlog, honors each request's leading gap.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            strobe_apply(req_now);   // answer queued before the count moves
            reqs_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (req_backlog.size() != 0 && req_wait >= req_backlog[0].gap) begin
               req_now = req_backlog.pop_front();
               req_wait = 0;
               req_ch.valid       <= 1'b1;
               req_ch.mode        <= req_now.mode;
               req_ch.delta_ms    <= req_now.delta_ms;
               req_ch.pixel_index <= req_now.pixel_index;
            end else begin
               req_ch.valid <= 1'b0;
               if (req_backlog.size() != 0)
                  req_wait++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: random back-pressure with calm stretches, in-order check.
   // ---------------------------------------------------------------------------
   function automatic void check_field(input string what, input logic [23:0] want,
                                       input logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_answer_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
         rsp_calm = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pixel_answers.size() == 0) begin
               $display("%0t: response expected none actual color %h drawn %b left %b on %b",
                        $time, rsp_ch.pixel_color, rsp_ch.pixel_drawn,
                        rsp_ch.left_side_lit, rsp_ch.flash_on);
               mismatches++;
            end else begin
               want = pixel_answers.pop_front();
               check_field("pixel_color", want.pixel_color, rsp_ch.pixel_color);
               check_field("pixel_drawn", 24'(want.pixel_drawn), 24'(rsp_ch.pixel_drawn));
               check_field("left_side_lit", 24'(want.left_side_lit),
                           24'(rsp_ch.left_side_lit));
               check_field("flash_on", 24'(want.flash_on), 24'(rsp_ch.flash_on));
            end
            if ($urandom_range(0, 31) == 0)
               rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 9);
         end
         rsp_ch.ready <= (rsp_wait == 0);
         if (rsp_wait != 0)
            rsp_wait--;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void queue_req(input logic [1:0] mode, input logic [15:0] delta,
                                     input logic [9:0] index);
      strobe_req_type r;
      r.mode = mode;
      r.delta_ms = delta;
      r.pixel_index = index;
      r.gap = req_calm ? 0 : $urandom_range(0, 9);
      req_backlog.push_back(r);
      reqs_queued++;
   endfunction

   // Wait until every request is taken and answered, then let ticks and
   // restarts clear the two pipeline registers before touching csr.
   task automatic wait_idle();
      while (reqs_taken != reqs_queued || pixel_answers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr valid high so back-to-back writes need one assignment per step.
   task automatic write_reg(input logic [tsp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [23:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         tsp_pkg::REG_ENABLED: begin
            if (val[0] && !cfg.enabled)
               anim = '0;   // rising enable restarts the animation
            cfg.enabled = val[0];
         end
         tsp_pkg::REG_PATTERN_FAST: cfg.pattern_fast     = val[0];
         tsp_pkg::REG_FAST_PERIOD:  cfg.fast_period_ms   = val[15:0];
         tsp_pkg::REG_SLOW_PERIOD:  cfg.slow_period_ms   = val[15:0];
         tsp_pkg::REG_FLASHES:      cfg.flashes_per_side = val[3:0];
         tsp_pkg::REG_LED_COUNT:    cfg.led_count        = val[10:0];
         tsp_pkg::REG_LEFT_COLOR:   cfg.left_color       = val;
         tsp_pkg::REG_RIGHT_COLOR:  cfg.right_color      = val;
         default: ;
      endcase
   endtask

   task automatic set_strobe_regs(input tsp_pkg::cfg_type c);
      // sometimes drop enable first so the 0->1 clear gets exercised
      if (c.enabled && $urandom_range(0, 2) == 0)
         write_reg(tsp_pkg::REG_ENABLED, 24'd0);
      write_reg(tsp_pkg::REG_PATTERN_FAST, 24'(c.pattern_fast));
      write_reg(tsp_pkg::REG_FAST_PERIOD,  24'(c.fast_period_ms));
      write_reg(tsp_pkg::REG_SLOW_PERIOD,  24'(c.slow_period_ms));
      write_reg(tsp_pkg::REG_FLASHES,      24'(c.flashes_per_side));
      write_reg(tsp_pkg::REG_LED_COUNT,    24'(c.led_count));
      write_reg(tsp_pkg::REG_LEFT_COLOR,   c.left_color);
      write_reg(tsp_pkg::REG_RIGHT_COLOR,  c.right_color);
      write_reg(tsp_pkg::REG_ENABLED,      24'(c.enabled));
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_period();
      case ($urandom_range(0, 9))
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 65535));
         default: return 16'($urandom_range(2, 400));
      endcase
   endfunction

   // Deltas scaled to the active period so flashes and side swaps actually happen.
   function automatic logic [15:0] pick_delta();
      int unsigned span;
      int unsigned flashes;
      flashes = cfg.flashes_per_side;
      span = cfg.pattern_fast ? cfg.fast_period_ms / (flashes + 1) : cfg.slow_period_ms / 3;
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
         default: return 16'($urandom_range(0, span + 1));
      endcase
   endfunction

   // Mostly LEDs on the strip, with the half split and the end of the strip hit often.
   function automatic logic [9:0] pick_index();
      int unsigned count;
      count = (cfg.led_count > tsp_pkg::MAX_LEDS) ? 32'(tsp_pkg::MAX_LEDS)
                                                  : 32'(cfg.led_count);
      case ($urandom_range(0, 7))
         0: return 10'($urandom);
         1: return 10'(count);
         2: return 10'(count / 2);
         3: return 10'(count / 2 - 1);
         default: return (count == 0) ? 10'($urandom) : 10'($urandom_range(0, count - 1));
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      tsp_pkg::cfg_type c;
      int unsigned      phase;
      int unsigned      n;
      int unsigned      k;
      int unsigned      roll;
      int unsigned      items_done;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = tsp_pkg::MODE_TICK;
      req_ch.delta_ms = '0;
      req_ch.pixel_index = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = tsp_pkg::REG_ENABLED;
      csr_ch.data = '0;
      req_backlog.delete();
      pixel_answers.delete();
      req_wait = 0;
      rsp_wait = 0;
      rsp_calm = 1'b0;
      reqs_queued = 0;
      reqs_taken = 0;
      mismatches = 0;
      req_calm = 1'b0;
      items_done = 0;

      cfg.enabled          = 1'b0;
      cfg.pattern_fast     = 1'b1;
      cfg.fast_period_ms   = 16'd500;
      cfg.slow_period_ms   = 16'd1000;
      cfg.flashes_per_side = 4'd3;
      cfg.led_count        = 11'd0;
      cfg.left_color       = 24'hFF0000;
      cfg.right_color      = 24'h0000FF;
      anim = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the effect is off: nothing drawn, ticks ignored, mode 3 dropped.
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_TICK, 16'd300, 10'd0);
      queue_req(tsp_pkg::MODE_RESTART, 16'd0, 10'd0);
      queue_req(MODE_UNUSED, 16'hFFFF, 10'h3FF);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'h3FF);
      wait_idle();

      // Strip longer than the cap; default fast pattern, edges of both halves.
      c = cfg;
      c.enabled = 1'b1;
      c.led_count = 11'h7FF;
      set_strobe_regs(c);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd511);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd512);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd1023);
      queue_req(tsp_pkg::MODE_TICK, 16'd100, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_TICK, 16'hFFFF, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd1023);
      queue_req(tsp_pkg::MODE_TICK, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd600);
      wait_idle();

      // Slow pattern with a zero slow period: position pinned, right side shown.
      c.pattern_fast = 1'b0;
      c.slow_period_ms = 16'd0;
      c.led_count = 11'd10;
      c.left_color = 24'hFFFFFF;
      c.right_color = 24'hA5A5A5;
      set_strobe_regs(c);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_TICK, 16'd5, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd9);
      wait_idle();

      // Fast with zero period and zero flashes: every tick completes and swaps.
      c.pattern_fast = 1'b1;
      c.fast_period_ms = 16'd0;
      c.flashes_per_side = 4'd0;
      c.slow_period_ms = 16'hFFFF;
      c.led_count = 11'd1;
      set_strobe_regs(c);
      queue_req(tsp_pkg::MODE_TICK, 16'd1, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_TICK, 16'd1, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_RESTART, 16'd0, 10'd0);
      queue_req(tsp_pkg::MODE_PIXEL, 16'd0, 10'd0);
      wait_idle();

      // Random phases: first one at the top extremes, second at the bottom ones.
      phase = 0;
      while (items_done < 400) begin
         c.enabled = ($urandom_range(0, 6) != 0);
         c.pattern_fast = $urandom_range(0, 1);
         c.fast_period_ms = pick_period();
         c.slow_period_ms = pick_period();
         c.flashes_per_side = ($urandom_range(0, 9) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         case ($urandom_range(0, 7))
            0: c.led_count = 11'd0;
            1: c.led_count = tsp_pkg::MAX_LEDS;
            2: c.led_count = 11'($urandom_range(1025, 2047));
            3: c.led_count = 11'($urandom);
            default: c.led_count = 11'($urandom_range(1, 64));
         endcase
         c.left_color = 24'($urandom);
         c.right_color = 24'($urandom);
         if (phase == 0) begin
            c.enabled = 1'b1;
            c.fast_period_ms = 16'hFFFF;
            c.slow_period_ms = 16'hFFFF;
            c.flashes_per_side = 4'd15;
            c.led_count = tsp_pkg::MAX_LEDS;
            c.left_color = 24'hFFFFFF;
            c.right_color = 24'hFFFFFF;
         end else if (phase == 1) begin
            c.enabled = 1'b1;
            c.fast_period_ms = 16'd1;
            c.slow_period_ms = 16'd1;
            c.flashes_per_side = 4'd1;
            c.led_count = 11'd2;
            c.left_color = 24'd0;
            c.right_color = 24'd0;
         end
         set_strobe_regs(c);
         req_calm = ($urandom_range(0, 3) == 0);

         n = $urandom_range(30, 70);
         for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 19) == 0)
               req_calm = !req_calm;
            roll = $urandom_range(0, 99);
            if (roll < 52)
               queue_req(tsp_pkg::MODE_PIXEL, 16'($urandom), pick_index());
            else if (roll < 92)
               queue_req(tsp_pkg::MODE_TICK, pick_delta(), 10'($urandom));
            else if (roll < 96)
               queue_req(tsp_pkg::MODE_RESTART, 16'($urandom), 10'($urandom));
            else
               queue_req(MODE_UNUSED, 16'($urandom), 10'($urandom));
            // unused mode and ticks while off change nothing
            if (roll < 96 && (cfg.enabled || roll < 52))
               items_done++;
         end
         wait_idle();
         phase++;
      end

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
